// ===== rtl/srt_pkg.sv =====
// package for the shell redirection tokenizer: types, codes and character constants
package srt_pkg;

    // default width of one command-line character
    localparam int CHAR_BITS_DEFAULT = 8;

    // depth of the result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_BITS = $clog2(RES_DEPTH);

    // characters that steer the parser
    localparam logic [7:0] CHR_LT    = 8'h3C;  // <
    localparam logic [7:0] CHR_GT    = 8'h3E;  // >
    localparam logic [7:0] CHR_PIPE  = 8'h7C;  // |
    localparam logic [7:0] CHR_TWO   = 8'h32;  // 2
    localparam logic [7:0] CHR_AMP   = 8'h26;  // &
    localparam logic [7:0] CHR_DQ    = 8'h22;  // double quote
    localparam logic [7:0] CHR_SQ    = 8'h27;  // single quote
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;  // first of the control blanks
    localparam logic [7:0] CHR_CR    = 8'h0D;  // last of the control blanks

    // flag bits
    localparam logic [4:0] FLAG_IN         = 5'b00001;
    localparam logic [4:0] FLAG_OUT        = 5'b00010;
    localparam logic [4:0] FLAG_OUT_APPEND = 5'b00100;
    localparam logic [4:0] FLAG_ERR        = 5'b01000;
    localparam logic [4:0] FLAG_ERR_APPEND = 5'b10000;

    localparam logic [7:0] COUNT_RESET = 8'd1;
    localparam logic [7:0] COUNT_MAX   = 8'd255;

    // parser modes
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_QUOTE   = 3'd1,
        MODE_PEND2   = 3'd2,
        MODE_PENDAMP = 3'd3,
        MODE_AFTERGT = 3'd4,
        MODE_SKIP    = 3'd5,
        MODE_NAME    = 3'd6
    } mode_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_CMD    = 3'd0,
        KIND_BOUND  = 3'd1,
        KIND_START  = 3'd2,
        KIND_NAMECH = 3'd3,
        KIND_DONE   = 3'd4
    } kind_t;

    // name targets
    typedef enum logic [1:0] {
        TGT_IN      = 2'd0,
        TGT_OUT     = 2'd1,
        TGT_ERR     = 2'd2,
        TGT_OUT_ERR = 2'd3
    } target_t;

    // one result transaction
    typedef struct packed {
        kind_t      kind;
        logic [7:0] chr;
        target_t    tgt;
        logic [4:0] flags;
        logic [7:0] count;
        logic       last;
    } result_t;

endpackage

// ===== rtl/shell_redirection_tokenizer_core.sv =====
// shell redirection tokenizer: character parser with a small result queue
//
// Usage: command-line characters enter on the input channel (ch, end_of_line)
// under in_valid / in_stall; results leave on the output channel (out_kind,
// out_char, target, flags, command_count, last) under out_valid / out_stall.
// A transaction is taken at a rising edge with valid high and stall low.
// Each input transaction yields zero, one or two result transactions; last
// marks the final one belonging to that input. end_of_line yields the line
// done result with the flags and command count and returns the parser to its
// reset state.
// The results of an input are registered in the queue and reach the output
// behind any earlier results still waiting there. Throughput: one input per
// cycle while in_stall is low; the output side moves one result per cycle
// while out_stall is low, so two-result inputs drain at that rate.
// The parser state is updated in the acceptance cycle and the results are
// written into a four entry queue; in_stall rises when fewer than two queue
// entries are free, so a receiver stall fills the queue and then stalls the
// input side while nothing is lost.
// Reset (rst_n low, asynchronous) empties the queue and puts the parser in
// normal text mode with flags zero and command count one.
module shell_redirection_tokenizer_core #(
    parameter int CHAR_BITS = srt_pkg::CHAR_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CHAR_BITS-1:0] ch,
    input  logic                 end_of_line,
    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           out_kind,
    output logic [7:0]           out_char,
    output logic [1:0]           target,
    output logic [4:0]           flags,
    output logic [7:0]           command_count,
    output logic                 last
);

    localparam int PTR_BITS = srt_pkg::RES_PTR_BITS;
    localparam int CNT_BITS = PTR_BITS + 1;

    // parser state
    srt_pkg::mode_t   mode_reg, mode_next;
    logic             quote_dq_reg, quote_dq_next;
    srt_pkg::target_t dest_reg, dest_next;
    logic [4:0]       flag_reg, flag_next;
    logic [7:0]       pipe_reg, pipe_next;

    // result queue
    srt_pkg::result_t     queue_reg [srt_pkg::RES_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    logic in_fire;
    logic out_fire;

    // character classes
    logic is_gt, is_lt, is_pipe, is_two, is_amp, is_dq, is_sq, is_blank, ends_name;
    logic quote_close;
    logic pend_mode;
    logic pre_valid;
    srt_pkg::mode_t eff_mode;

    // results of this input
    srt_pkg::result_t pre_res, main_res, res0, res1;
    logic             main_valid;
    logic [1:0]       res_num;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    // stall while fewer than two free queue entries
    assign in_stall  = count_reg > CNT_BITS'(srt_pkg::RES_DEPTH - 2);
    assign out_valid = count_reg != '0;

    // character decode
    always_comb
    begin
        is_gt    = ch == CHAR_BITS'(srt_pkg::CHR_GT);
        is_lt    = ch == CHAR_BITS'(srt_pkg::CHR_LT);
        is_pipe  = ch == CHAR_BITS'(srt_pkg::CHR_PIPE);
        is_two   = ch == CHAR_BITS'(srt_pkg::CHR_TWO);
        is_amp   = ch == CHAR_BITS'(srt_pkg::CHR_AMP);
        is_dq    = ch == CHAR_BITS'(srt_pkg::CHR_DQ);
        is_sq    = ch == CHAR_BITS'(srt_pkg::CHR_SQ);
        is_blank = (ch == CHAR_BITS'(srt_pkg::CHR_SPACE))
                   || (ch >= CHAR_BITS'(srt_pkg::CHR_TAB) && ch <= CHAR_BITS'(srt_pkg::CHR_CR));
        ends_name   = is_blank || is_lt || is_gt || is_pipe;
        quote_close = quote_dq_reg ? is_dq : is_sq;
    end

    // resolve the mode that finally handles this character
    always_comb
    begin
        srt_pkg::mode_t m1;
        srt_pkg::mode_t m2;
        pend_mode = (mode_reg == srt_pkg::MODE_PEND2) || (mode_reg == srt_pkg::MODE_PENDAMP);
        pre_valid = pend_mode && (end_of_line || !is_gt);
        // pending 2 or & falls back to normal text, lone > goes on to blank skip
        unique case (mode_reg)
            srt_pkg::MODE_NORMAL:  m1 = srt_pkg::MODE_NORMAL;
            srt_pkg::MODE_QUOTE:   m1 = srt_pkg::MODE_QUOTE;
            srt_pkg::MODE_PEND2:   m1 = is_gt ? srt_pkg::MODE_PEND2 : srt_pkg::MODE_NORMAL;
            srt_pkg::MODE_PENDAMP: m1 = is_gt ? srt_pkg::MODE_PENDAMP : srt_pkg::MODE_NORMAL;
            srt_pkg::MODE_AFTERGT: m1 = is_gt ? srt_pkg::MODE_AFTERGT : srt_pkg::MODE_SKIP;
            srt_pkg::MODE_SKIP:    m1 = srt_pkg::MODE_SKIP;
            srt_pkg::MODE_NAME:    m1 = srt_pkg::MODE_NAME;
            default:               m1 = srt_pkg::MODE_NORMAL;
        endcase
        // first non-blank starts the name
        m2 = (m1 == srt_pkg::MODE_SKIP && !is_blank) ? srt_pkg::MODE_NAME : m1;
        // a name terminator goes back to normal text and is handled there
        eff_mode = (m2 == srt_pkg::MODE_NAME && ends_name) ? srt_pkg::MODE_NORMAL : m2;
    end

    // next parser state
    always_comb
    begin
        mode_next     = mode_reg;
        quote_dq_next = quote_dq_reg;
        dest_next     = dest_reg;
        flag_next     = flag_reg;
        pipe_next     = pipe_reg;
        if (end_of_line)
        begin
            mode_next     = srt_pkg::MODE_NORMAL;
            quote_dq_next = 1'b0;
            dest_next     = srt_pkg::TGT_IN;
            flag_next     = '0;
            pipe_next     = srt_pkg::COUNT_RESET;
        end
        else
        begin
            mode_next = eff_mode;
            unique case (eff_mode)
                srt_pkg::MODE_NORMAL:
                begin
                    if (is_dq || is_sq)
                    begin
                        mode_next     = srt_pkg::MODE_QUOTE;
                        quote_dq_next = is_dq;
                    end
                    else if (is_lt)
                    begin
                        flag_next = flag_reg | srt_pkg::FLAG_IN;
                        dest_next = srt_pkg::TGT_IN;
                        mode_next = srt_pkg::MODE_SKIP;
                    end
                    else if (is_gt)
                    begin
                        flag_next = flag_reg | srt_pkg::FLAG_OUT;
                        dest_next = srt_pkg::TGT_OUT;
                        mode_next = srt_pkg::MODE_AFTERGT;
                    end
                    else if (is_two)
                    begin
                        mode_next = srt_pkg::MODE_PEND2;
                    end
                    else if (is_amp)
                    begin
                        mode_next = srt_pkg::MODE_PENDAMP;
                    end
                    else if (is_pipe)
                    begin
                        if (pipe_reg != srt_pkg::COUNT_MAX)
                        begin
                            pipe_next = pipe_reg + 8'd1;
                        end
                    end
                end
                srt_pkg::MODE_QUOTE:
                begin
                    if (quote_close)
                    begin
                        mode_next     = srt_pkg::MODE_NORMAL;
                        quote_dq_next = 1'b0;
                    end
                end
                srt_pkg::MODE_PEND2:
                begin
                    flag_next = flag_reg | srt_pkg::FLAG_ERR;
                    dest_next = srt_pkg::TGT_ERR;
                    mode_next = srt_pkg::MODE_AFTERGT;
                end
                srt_pkg::MODE_PENDAMP:
                begin
                    flag_next = flag_reg | srt_pkg::FLAG_OUT | srt_pkg::FLAG_ERR;
                    dest_next = srt_pkg::TGT_OUT_ERR;
                    mode_next = srt_pkg::MODE_AFTERGT;
                end
                srt_pkg::MODE_AFTERGT:
                begin
                    // second > turns on append for the current target
                    if (dest_reg == srt_pkg::TGT_OUT || dest_reg == srt_pkg::TGT_OUT_ERR)
                    begin
                        flag_next = flag_next | srt_pkg::FLAG_OUT_APPEND;
                    end
                    if (dest_reg == srt_pkg::TGT_ERR || dest_reg == srt_pkg::TGT_OUT_ERR)
                    begin
                        flag_next = flag_next | srt_pkg::FLAG_ERR_APPEND;
                    end
                    mode_next = srt_pkg::MODE_SKIP;
                end
                srt_pkg::MODE_SKIP:
                begin
                    mode_next = srt_pkg::MODE_SKIP;
                end
                srt_pkg::MODE_NAME:
                begin
                    mode_next = srt_pkg::MODE_NAME;
                end
                default:
                begin
                    mode_next = srt_pkg::MODE_NORMAL;
                end
            endcase
        end
    end

    // results of this input
    always_comb
    begin
        pre_res       = '0;
        pre_res.kind  = srt_pkg::KIND_CMD;
        pre_res.chr   = (mode_reg == srt_pkg::MODE_PEND2) ? srt_pkg::CHR_TWO : srt_pkg::CHR_AMP;
        main_res      = '0;
        main_valid    = 1'b0;
        if (end_of_line)
        begin
            main_valid     = 1'b1;
            main_res.kind  = srt_pkg::KIND_DONE;
            main_res.flags = flag_reg;
            main_res.count = pipe_reg;
        end
        else
        begin
            unique case (eff_mode)
                srt_pkg::MODE_NORMAL:
                begin
                    if (is_lt)
                    begin
                        main_valid    = 1'b1;
                        main_res.kind = srt_pkg::KIND_START;
                        main_res.tgt  = srt_pkg::TGT_IN;
                    end
                    else if (is_gt)
                    begin
                        main_valid    = 1'b1;
                        main_res.kind = srt_pkg::KIND_START;
                        main_res.tgt  = srt_pkg::TGT_OUT;
                    end
                    else if (is_pipe)
                    begin
                        main_valid    = 1'b1;
                        main_res.kind = srt_pkg::KIND_BOUND;
                    end
                    else if (!is_two && !is_amp)
                    begin
                        main_valid    = 1'b1;
                        main_res.kind = srt_pkg::KIND_CMD;
                        main_res.chr  = ch[7:0];
                    end
                end
                srt_pkg::MODE_QUOTE:
                begin
                    main_valid    = 1'b1;
                    main_res.kind = srt_pkg::KIND_CMD;
                    main_res.chr  = ch[7:0];
                end
                srt_pkg::MODE_PEND2:
                begin
                    main_valid    = 1'b1;
                    main_res.kind = srt_pkg::KIND_START;
                    main_res.tgt  = srt_pkg::TGT_ERR;
                end
                srt_pkg::MODE_PENDAMP:
                begin
                    main_valid    = 1'b1;
                    main_res.kind = srt_pkg::KIND_START;
                    main_res.tgt  = srt_pkg::TGT_OUT_ERR;
                end
                srt_pkg::MODE_NAME:
                begin
                    main_valid    = 1'b1;
                    main_res.kind = srt_pkg::KIND_NAMECH;
                    main_res.chr  = ch[7:0];
                    main_res.tgt  = dest_reg;
                end
                default:
                begin
                    main_valid = 1'b0;
                end
            endcase
        end
        main_res.last = 1'b1;
        pre_res.last  = !main_valid;
        res0    = pre_valid ? pre_res : main_res;
        res1    = main_res;
        res_num = {1'b0, pre_valid} + {1'b0, main_valid};
    end

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_fire)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_BITS'(res_num);
            count_next  = count_next + CNT_BITS'(res_num);
        end
        if (out_fire)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_BITS'(1);
            count_next  = count_next - CNT_BITS'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= srt_pkg::MODE_NORMAL;
            quote_dq_reg <= 1'b0;
            dest_reg     <= srt_pkg::TGT_IN;
            flag_reg     <= '0;
            pipe_reg     <= srt_pkg::COUNT_RESET;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg     <= mode_next;
                quote_dq_reg <= quote_dq_next;
                dest_reg     <= dest_next;
                flag_reg     <= flag_next;
                pipe_reg     <= pipe_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (in_fire && res_num != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (in_fire && res_num == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTR_BITS'(1)] <= res1;
        end
    end

    // output fields
    always_comb
    begin
        srt_pkg::result_t head;
        head          = queue_reg[rd_ptr_reg];
        out_kind      = head.kind;
        out_char      = head.chr;
        target        = head.tgt;
        flags         = head.flags;
        command_count = head.count;
        last          = head.last;
    end

    // queue never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(srt_pkg::RES_DEPTH))
        else $error("result queue overflow");

    // end of line returns the parser to its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_line |=> mode_reg == srt_pkg::MODE_NORMAL
                                   && flag_reg == '0 && pipe_reg == srt_pkg::COUNT_RESET)
        else $error("parser state not cleared at end of line");

    // command count is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        pipe_reg != '0)
        else $error("command count reached zero");

    // flags and count only travel with line done
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != srt_pkg::KIND_DONE |-> flags == '0 && command_count == '0)
        else $error("flags or count on a result other than line done");

    // a lone 2 or & followed by a character other than >, 2 or & gives two results
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && pend_mode && !end_of_line && !is_gt && !is_two && !is_amp
        |-> res_num == 2'd2)
        else $error("pending character lost");

endmodule

// ===== test/shell_redirection_tokenizer_core_tb.sv =====
// testbench for the shell redirection tokenizer core
`timescale 1ns / 1ps

module shell_redirection_tokenizer_core_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS  = 30;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] ch          = '0;
    logic       end_of_line = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [2:0] out_kind;
    logic [7:0] out_char;
    logic [1:0] target;
    logic [4:0] flags;
    logic [7:0] command_count;
    logic       last;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int errors     = 0;
    int cycles     = 0;
    int sent_items = 0;

    // tokens still owed by the block, oldest first
    srt_pkg::result_t token_q [$];

    // shadow parser state
    srt_pkg::mode_t   p_mode  = srt_pkg::MODE_NORMAL;
    logic [7:0]       p_quote = '0;
    srt_pkg::target_t p_dest  = srt_pkg::TGT_IN;
    logic [4:0]       p_flags = '0;
    logic [7:0]       p_pipes = srt_pkg::COUNT_RESET;

    shell_redirection_tokenizer_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ch            (ch),
        .end_of_line   (end_of_line),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_kind      (out_kind),
        .out_char      (out_char),
        .target        (target),
        .flags         (flags),
        .command_count (command_count),
        .last          (last)
    );

    always #10 clk = ~clk;

    // receiver stall pattern
    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // run time guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == srt_pkg::CHR_SPACE || (c >= srt_pkg::CHR_TAB && c <= srt_pkg::CHR_CR);
    endfunction

    function automatic void add_token(srt_pkg::kind_t kind, logic [7:0] c,
                                      srt_pkg::target_t tgt,
                                      logic [4:0] fl, logic [7:0] cnt);
        srt_pkg::result_t r;
        r.kind  = kind;
        r.chr   = c;
        r.tgt   = tgt;
        r.flags = fl;
        r.count = cnt;
        r.last  = 1'b0;
        token_q.push_back(r);
    endfunction

    function automatic void open_name(srt_pkg::target_t dest, srt_pkg::mode_t next_mode);
        p_dest = dest;
        add_token(srt_pkg::KIND_START, '0, dest, '0, '0);
        p_mode = next_mode;
    endfunction

    // work out the tokens for one accepted character
    function automatic void tokenize(logic [7:0] c, logic eol);
        int prior_size;
        bit again;
        prior_size = token_q.size();
        if (eol)
        begin
            if (p_mode == srt_pkg::MODE_PEND2)
                add_token(srt_pkg::KIND_CMD, srt_pkg::CHR_TWO, srt_pkg::TGT_IN, '0, '0);
            else if (p_mode == srt_pkg::MODE_PENDAMP)
                add_token(srt_pkg::KIND_CMD, srt_pkg::CHR_AMP, srt_pkg::TGT_IN, '0, '0);
            add_token(srt_pkg::KIND_DONE, '0, srt_pkg::TGT_IN, p_flags, p_pipes);
            p_mode  = srt_pkg::MODE_NORMAL;
            p_quote = '0;
            p_dest  = srt_pkg::TGT_IN;
            p_flags = '0;
            p_pipes = srt_pkg::COUNT_RESET;
        end
        else
        begin
            again = 1'b1;
            while (again)
            begin
                again = 1'b0;
                case (p_mode)
                    srt_pkg::MODE_NORMAL:
                    begin
                        if (c == srt_pkg::CHR_DQ || c == srt_pkg::CHR_SQ)
                        begin
                            p_quote = c;
                            p_mode  = srt_pkg::MODE_QUOTE;
                            add_token(srt_pkg::KIND_CMD, c, srt_pkg::TGT_IN, '0, '0);
                        end
                        else if (c == srt_pkg::CHR_LT)
                        begin
                            p_flags |= srt_pkg::FLAG_IN;
                            open_name(srt_pkg::TGT_IN, srt_pkg::MODE_SKIP);
                        end
                        else if (c == srt_pkg::CHR_GT)
                        begin
                            p_flags |= srt_pkg::FLAG_OUT;
                            open_name(srt_pkg::TGT_OUT, srt_pkg::MODE_AFTERGT);
                        end
                        else if (c == srt_pkg::CHR_TWO)
                            p_mode = srt_pkg::MODE_PEND2;
                        else if (c == srt_pkg::CHR_AMP)
                            p_mode = srt_pkg::MODE_PENDAMP;
                        else if (c == srt_pkg::CHR_PIPE)
                        begin
                            if (p_pipes != srt_pkg::COUNT_MAX)
                                p_pipes++;
                            add_token(srt_pkg::KIND_BOUND, '0, srt_pkg::TGT_IN, '0, '0);
                        end
                        else
                            add_token(srt_pkg::KIND_CMD, c, srt_pkg::TGT_IN, '0, '0);
                    end
                    srt_pkg::MODE_QUOTE:
                    begin
                        add_token(srt_pkg::KIND_CMD, c, srt_pkg::TGT_IN, '0, '0);
                        if (c == p_quote)
                        begin
                            p_quote = '0;
                            p_mode  = srt_pkg::MODE_NORMAL;
                        end
                    end
                    srt_pkg::MODE_PEND2:
                    begin
                        if (c == srt_pkg::CHR_GT)
                        begin
                            p_flags |= srt_pkg::FLAG_ERR;
                            open_name(srt_pkg::TGT_ERR, srt_pkg::MODE_AFTERGT);
                        end
                        else
                        begin
                            add_token(srt_pkg::KIND_CMD, srt_pkg::CHR_TWO, srt_pkg::TGT_IN,
                                      '0, '0);
                            p_mode = srt_pkg::MODE_NORMAL;
                            again  = 1'b1;
                        end
                    end
                    srt_pkg::MODE_PENDAMP:
                    begin
                        if (c == srt_pkg::CHR_GT)
                        begin
                            p_flags |= srt_pkg::FLAG_OUT | srt_pkg::FLAG_ERR;
                            open_name(srt_pkg::TGT_OUT_ERR, srt_pkg::MODE_AFTERGT);
                        end
                        else
                        begin
                            add_token(srt_pkg::KIND_CMD, srt_pkg::CHR_AMP, srt_pkg::TGT_IN,
                                      '0, '0);
                            p_mode = srt_pkg::MODE_NORMAL;
                            again  = 1'b1;
                        end
                    end
                    srt_pkg::MODE_AFTERGT:
                    begin
                        p_mode = srt_pkg::MODE_SKIP;
                        if (c == srt_pkg::CHR_GT)
                        begin
                            if (p_dest == srt_pkg::TGT_OUT || p_dest == srt_pkg::TGT_OUT_ERR)
                                p_flags |= srt_pkg::FLAG_OUT_APPEND;
                            if (p_dest == srt_pkg::TGT_ERR || p_dest == srt_pkg::TGT_OUT_ERR)
                                p_flags |= srt_pkg::FLAG_ERR_APPEND;
                        end
                        else
                            again = 1'b1;
                    end
                    srt_pkg::MODE_SKIP:
                    begin
                        if (!is_blank(c))
                        begin
                            p_mode = srt_pkg::MODE_NAME;
                            again  = 1'b1;
                        end
                    end
                    srt_pkg::MODE_NAME:
                    begin
                        if (is_blank(c) || c == srt_pkg::CHR_LT || c == srt_pkg::CHR_GT
                            || c == srt_pkg::CHR_PIPE)
                        begin
                            p_mode = srt_pkg::MODE_NORMAL;
                            again  = 1'b1;
                        end
                        else
                            add_token(srt_pkg::KIND_NAMECH, c, p_dest, '0, '0);
                    end
                    default:
                    begin
                        p_mode = srt_pkg::MODE_NORMAL;
                        again  = 1'b1;
                    end
                endcase
            end
        end
        // final token of this character carries last
        if (token_q.size() > prior_size)
            token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h got %0h", field, want, got);
            errors++;
        end
    endfunction

    // compare each result transaction with the oldest owed token
    always @(negedge clk)
    begin : check_results
        srt_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (token_q.size() == 0)
            begin
                $error("unexpected result: out_kind %0d out_char %0h", out_kind, out_char);
                errors++;
            end
            else
            begin
                want = token_q.pop_front();
                check_field("out_kind", 8'(want.kind), 8'(out_kind));
                check_field("out_char", want.chr, out_char);
                check_field("target", 8'(want.tgt), 8'(target));
                check_field("flags", 8'(want.flags), 8'(flags));
                check_field("command_count", want.count, command_count);
                check_field("last", 8'(want.last), 8'(last));
            end
        end
    end

    // one input transaction, with random sender gaps ahead of it
    task automatic send_item(input logic [7:0] c, input logic eol);
        bit stalled;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        ch          <= c;
        end_of_line <= eol;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        tokenize(c, eol);
        sent_items++;
    endtask

    task automatic end_line();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (token_q.size() != 0);
    endtask

    task automatic send_blank();
        if ($urandom_range(1))
            send_item(srt_pkg::CHR_SPACE, 1'b0);
        else
            send_item(8'($urandom_range(srt_pkg::CHR_TAB, srt_pkg::CHR_CR)), 1'b0);
    endtask

    // mostly letters and digits, now and then any byte
    function automatic logic [7:0] word_char();
        case ($urandom_range(7))
            0:       return 8'($urandom_range(255));
            1:       return 8'($urandom_range(8'h30, 8'h39));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    task automatic send_operator();
        case ($urandom_range(6))
            0: send_item(srt_pkg::CHR_LT, 1'b0);
            1: send_item(srt_pkg::CHR_GT, 1'b0);
            2:
            begin
                send_item(srt_pkg::CHR_GT, 1'b0);
                send_item(srt_pkg::CHR_GT, 1'b0);
            end
            3:
            begin
                send_item(srt_pkg::CHR_TWO, 1'b0);
                send_item(srt_pkg::CHR_GT, 1'b0);
            end
            4:
            begin
                send_item(srt_pkg::CHR_TWO, 1'b0);
                send_item(srt_pkg::CHR_GT, 1'b0);
                send_item(srt_pkg::CHR_GT, 1'b0);
            end
            5:
            begin
                send_item(srt_pkg::CHR_AMP, 1'b0);
                send_item(srt_pkg::CHR_GT, 1'b0);
            end
            default:
            begin
                send_item(srt_pkg::CHR_AMP, 1'b0);
                send_item(srt_pkg::CHR_GT, 1'b0);
                send_item(srt_pkg::CHR_GT, 1'b0);
            end
        endcase
    endtask

    // one random piece of a command line
    task automatic send_token();
        logic [7:0] q;
        int         pick;
        pick = $urandom_range(19);
        if (pick <= 4)
        begin
            repeat ($urandom_range(1, 4)) send_item(word_char(), 1'b0);
        end
        else if (pick <= 6)
            send_blank();
        else if (pick <= 10)
        begin
            // redirection with optional blanks and a name
            send_operator();
            repeat ($urandom_range(2)) send_blank();
            repeat ($urandom_range(4)) send_item(word_char(), 1'b0);
        end
        else if (pick <= 12)
        begin
            q = $urandom_range(1) ? srt_pkg::CHR_DQ : srt_pkg::CHR_SQ;
            send_item(q, 1'b0);
            repeat ($urandom_range(5)) send_item(8'($urandom_range(255)), 1'b0);
            send_item(q, 1'b0);
        end
        else if (pick <= 14)
            send_item(srt_pkg::CHR_PIPE, 1'b0);
        else if (pick <= 16)
            send_item(8'($urandom_range(255)), 1'b0);
        else if (pick == 17)
            send_item($urandom_range(1) ? srt_pkg::CHR_TWO : srt_pkg::CHR_AMP, 1'b0);
        else if (pick == 18)
            end_line();
        else
        begin
            // broken sequence: bare operator with no name
            send_operator();
            if ($urandom_range(1))
                end_line();
        end
    endtask

    // lone 2 before a zero byte, input name of 0xff, 2>> with a name cut by a pipe,
    // pending ampersand at line end
    task automatic test_operators();
        send_item(srt_pkg::CHR_TWO, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(srt_pkg::CHR_LT, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(srt_pkg::CHR_SPACE, 1'b0);
        send_item(srt_pkg::CHR_TWO, 1'b0);
        send_item(srt_pkg::CHR_GT, 1'b0);
        send_item(srt_pkg::CHR_GT, 1'b0);
        send_item("e", 1'b0);
        send_item(srt_pkg::CHR_PIPE, 1'b0);
        send_item(srt_pkg::CHR_AMP, 1'b0);
        end_line();
        wait_drained();
    endtask

    // quoted pipe passes through, then &>> left hanging at line end
    task automatic test_quotes_and_pipes();
        send_item(srt_pkg::CHR_DQ, 1'b0);
        send_item(srt_pkg::CHR_PIPE, 1'b0);
        send_item(srt_pkg::CHR_DQ, 1'b0);
        send_item(srt_pkg::CHR_AMP, 1'b0);
        send_item(srt_pkg::CHR_GT, 1'b0);
        send_item(srt_pkg::CHR_GT, 1'b0);
        end_line();
        wait_drained();
    endtask

    // pending 2, open quote, repeated output redirection with an empty name
    task automatic test_line_end_cases();
        send_item(srt_pkg::CHR_TWO, 1'b0);
        end_line();
        send_item(srt_pkg::CHR_SQ, 1'b0);
        end_line();
        send_item(srt_pkg::CHR_GT, 1'b0);
        send_item("o", 1'b0);
        send_item(srt_pkg::CHR_GT, 1'b0);
        send_item(srt_pkg::CHR_GT, 1'b0);
        end_line();
        wait_drained();
    endtask

    // command count stops at its maximum
    task automatic test_count_saturation();
        stall_pct = 46;
        repeat (260) send_item(srt_pkg::CHR_PIPE, 1'b0);
        end_line();
        wait_drained();
        stall_pct = 0;
    endtask

    // random command lines under each idling pattern
    task automatic test_random_traffic();
        int  phase;
        int  goal;
        bit  paused;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 46;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 46;
                end
                default:
                begin
                    idle_pct  = 8;
                    stall_pct = 8;
                end
            endcase
            goal   = sent_items + PHASE_ITEMS;
            paused = 1'b0;
            while (sent_items < goal)
            begin
                send_token();
                // hold off mid line until the block has caught up
                if (phase == 2 && !paused && sent_items >= goal - PHASE_ITEMS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            end_line();
            wait_drained();
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_operators();
        test_quotes_and_pipes();
        test_line_end_cases();
        test_count_saturation();
        test_random_traffic();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
